[rtl/core/dcla_pkg.sv]
// Shared types and constants for the delimited command line assembler.
package dcla_pkg;

  localparam int unsigned LineDepth = 64;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] REG_DELIM_PRI = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_DELIM_SEC = 1'b1;

  localparam logic [ByteW-1:0] DelimPriRst = 8'd13;
  localparam logic [ByteW-1:0] DelimSecRst = 8'd10;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_OVERFLOW,
    ST_REPLAY
  } state_e;

  typedef struct packed {
    logic  wr_en;
    logic  fill_inc;
    logic  fill_clr;
    logic  rd_start;
    logic  rd_next;
    logic  load_single;
    logic  load_byte;
    kind_e single_kind;
  } dcla_cmd_t;

  typedef struct packed {
    logic is_delim;
    logic fill_zero;
    logic fill_full;
    logic rd_last;
    logic out_free;
  } dcla_stat_t;

endpackage

[rtl/core/dcla_datapath.sv]
// Datapath: delimiter registers, line store, fill and replay counters, output register.
module dcla_datapath #(
  parameter int unsigned LINE_DEPTH = dcla_pkg::LineDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dcla_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dcla_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic [dcla_pkg::ByteW-1:0]   rx_byte_i,
  input  dcla_pkg::dcla_cmd_t          cmd_i,
  output dcla_pkg::dcla_stat_t         stat_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   result_kind_o,
  output logic [dcla_pkg::ByteW-1:0]   out_byte_o,
  output logic                         last_o
);
  import dcla_pkg::*;

  localparam int unsigned PosW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(LINE_DEPTH - 1);

  logic [ByteW-1:0] delim_pri_q;
  logic [ByteW-1:0] delim_sec_q;
  logic [PosW-1:0]  fill_q, fill_d;
  logic [PosW-1:0]  rd_idx_q, rd_idx_d;
  logic [PosW-1:0]  rd_addr;
  logic             rd_en;
  logic [ByteW-1:0] mem [LINE_DEPTH];
  logic [ByteW-1:0] rd_data_q;
  logic             out_valid_q, out_valid_d;
  kind_e            kind_q;
  logic [ByteW-1:0] byte_q;
  logic             last_q;
  logic             rd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_pri_q <= DelimPriRst;
      delim_sec_q <= DelimSecRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELIM_PRI: delim_pri_q <= cfg_wdata_i;
        REG_DELIM_SEC: delim_sec_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
    end else if (cmd_i.fill_inc) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  assign rd_addr = cmd_i.rd_next ? rd_idx_q + 1'b1 : '0;
  assign rd_en   = cmd_i.rd_start | cmd_i.rd_next;
  assign rd_last = (rd_idx_q == fill_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_idx_q <= '0;
    end else begin
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[fill_q] <= rx_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_single || cmd_i.load_byte) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      kind_q <= cmd_i.single_kind;
      byte_q <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.load_byte) begin
      kind_q <= KIND_BYTE;
      byte_q <= rd_data_q;
      last_q <= rd_last;
    end
  end

  assign stat_o.is_delim  = (rx_byte_i == delim_pri_q) || (rx_byte_i == delim_sec_q);
  assign stat_o.fill_zero = (fill_q == '0);
  assign stat_o.fill_full = (fill_q == LastPos);
  assign stat_o.rd_last   = rd_last;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign out_byte_o    = byte_q;
  assign last_o        = last_q;

endmodule

[rtl/core/dcla_ctrl.sv]
// Controller: state machine that sequences store writes, replay and result loads.
module dcla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dcla_pkg::dcla_stat_t stat_i,
  output dcla_pkg::dcla_cmd_t  cmd_o
);
  import dcla_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.single_kind = KIND_EMPTY;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.is_delim) begin
            if (stat_i.fill_zero) begin
              state_d = ST_EMPTY;
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = ST_REPLAY;
            end
          end else begin
            cmd_o.wr_en = 1'b1;
            if (stat_i.fill_full) begin
              cmd_o.fill_clr = 1'b1;
              state_d        = ST_OVERFLOW;
            end else begin
              cmd_o.fill_inc = 1'b1;
            end
          end
        end
      end
      ST_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.load_single = 1'b1;
          cmd_o.single_kind = KIND_EMPTY;
          state_d           = ST_IDLE;
        end
      end
      ST_OVERFLOW: begin
        if (stat_i.out_free) begin
          cmd_o.load_single = 1'b1;
          cmd_o.single_kind = KIND_OVERFLOW;
          state_d           = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        if (stat_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          if (stat_i.rd_last) begin
            cmd_o.fill_clr = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/delimited_command_line_assembler_core.sv]
// An ordinary byte is written to the line store; an empty-line or overflow result passes
// through its EMPTY or OVERFLOW state into the output register; a stored line of n bytes
// is replayed from the REPLAY state, one byte per cycle while the output register is free.
// Input is accepted only in the idle state, so not while a result or a line is pending.
// Reset clears the fill count, the controller and the output valid, and loads the
// delimiters with 13 and 10; the line store is not cleared.
module delimited_command_line_assembler_core #(
  parameter int unsigned LINE_DEPTH = dcla_pkg::LineDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dcla_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dcla_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dcla_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   result_kind_o,
  output logic [dcla_pkg::ByteW-1:0]   out_byte_o,
  output logic                         last_o
);
  import dcla_pkg::*;

  dcla_cmd_t  cmd;
  dcla_stat_t stat;

  dcla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dcla_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .result_kind_o (result_kind_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o)
  );

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the delimited command line assembler core.
module tb_top;
  import dcla_pkg::*;

  localparam int StallLimit = 4000;
  localparam int SettleCycles = 4;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } line_result_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = REG_DELIM_PRI;
  logic [ByteW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         result_kind_o;
  logic [ByteW-1:0]   out_byte_o;
  logic               last_o;

  logic [ByteW-1:0] rx_pending_q[$];
  line_result_t     line_results_q[$];

  logic [ByteW-1:0] shadow_store[LineDepth];
  int unsigned      shadow_fill = 0;
  logic [ByteW-1:0] shadow_delim_pri = DelimPriRst;
  logic [ByteW-1:0] shadow_delim_sec = DelimSecRst;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int bytes_sent = 0;
  int line_bytes_seen = 0;
  int empty_lines_seen = 0;
  int overflows_seen = 0;
  int stall_cnt = 0;

  delimited_command_line_assembler_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void predict_line_results(input logic [ByteW-1:0] rx);
    int unsigned pos;
    pos = shadow_fill;
    if (rx != shadow_delim_pri && rx != shadow_delim_sec) begin
      shadow_store[pos] = rx;
      if (pos < LineDepth - 1) begin
        shadow_fill = pos + 1;
      end else begin
        shadow_fill = 0;
        line_results_q.push_back('{KIND_OVERFLOW, '0, 1'b1});
      end
    end else begin
      shadow_fill = 0;
      if (pos == 0) begin
        line_results_q.push_back('{KIND_EMPTY, '0, 1'b1});
      end else begin
        for (int unsigned i = 0; i < pos; i++) begin
          line_results_q.push_back('{KIND_BYTE, shadow_store[i], (i + 1 == pos)});
        end
      end
    end
  endfunction

  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    do begin
      b = ByteW'($urandom_range(0, 255));
    end while (b == shadow_delim_pri || b == shadow_delim_sec);
    return b;
  endfunction

  task automatic add_line(input int len);
    for (int i = 0; i < len; i++) begin
      rx_pending_q.push_back(plain_byte());
    end
    rx_pending_q.push_back($urandom_range(0, 1) ? shadow_delim_pri : shadow_delim_sec);
  endtask

  task automatic add_random_lines(input int target);
    int queued;
    int len;
    queued = 0;
    while (queued < target) begin
      len = $urandom_range(0, 12);
      add_line(len);
      queued += len + 1;
    end
  endtask

  task automatic drain();
    while (rx_pending_q.size() != 0 || in_valid_i || line_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_delims(input logic [ByteW-1:0] pri, input logic [ByteW-1:0] sec);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DELIM_PRI;
    cfg_wdata_i <= pri;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DELIM_SEC;
    cfg_wdata_i <= sec;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_delim_pri = pri;
    shadow_delim_sec = sec;
  endtask

  // Feed input items from the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_line_results(rx_byte_i);
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (rx_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Check each result item against the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    line_result_t exp_r;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (line_results_q.size() == 0) begin
          $error("unexpected item: result_kind %0d out_byte 0x%02h last %0b",
                 result_kind_o, out_byte_o, last_o);
          errors++;
        end else begin
          exp_r = line_results_q.pop_front();
          if (result_kind_o !== exp_r.kind) begin
            $error("result_kind: expected %0d, got %0d", exp_r.kind, result_kind_o);
            errors++;
          end
          if (out_byte_o !== exp_r.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", exp_r.data, out_byte_o);
            errors++;
          end
          if (last_o !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, last_o);
            errors++;
          end
          case (exp_r.kind)
            KIND_BYTE:     line_bytes_seen++;
            KIND_EMPTY:    empty_lines_seen++;
            KIND_OVERFLOW: overflows_seen++;
            default: ;
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= StallLimit) begin
        $display("Timeout: no item moved for %0d cycles", StallLimit);
        $display("Test completed with failures");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 87;
    // Reset delimiters: empty lines on both, zero and extreme bytes, short lines.
    rx_pending_q = '{8'd13, 8'd10,
                     8'h00, 8'hFF, 8'h00, 8'd13,
                     8'h01, 8'h80, 8'h7F, 8'hFE, 8'd10,
                     8'h55, 8'd13};
    drain();

    write_delims(8'h41, 8'h41);
    rx_pending_q.push_back(8'h41);
    rx_pending_q.push_back(8'h42);
    rx_pending_q.push_back(8'h00);
    rx_pending_q.push_back(8'h41);
    add_random_lines(4);
    drain();

    send_idle_pct = 87;
    recv_idle_pct = 28;
    write_delims(8'h00, 8'hFF);
    add_line(LineDepth - 1);
    add_random_lines(4);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_delims(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
    // Overrun the store, then keep going on the restarted line.
    for (int i = 0; i < LineDepth; i++) begin
      rx_pending_q.push_back(plain_byte());
    end
    add_line(5);
    add_random_lines(4);
    drain();

    $display("Sent %0d bytes under four delimiter settings and three idling patterns.",
             bytes_sent);
    $display("Checked %0d line bytes, %0d empty lines and %0d overflows.",
             line_bytes_seen, empty_lines_seen, overflows_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
